// File: design/grouped_quartile_estimator_assert.svh
// assertion macros for the grouped quartile estimator
// included by the rtl files that carry concurrent assertions; no other dependencies
`ifndef GROUPED_QUARTILE_ESTIMATOR_ASSERT_SVH
`define GROUPED_QUARTILE_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GQE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gqe assertion failed");
// antecedent implies consequent in the next cycle
`define GQE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gqe assertion failed");
`else
`define GQE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GQE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: design/gqe_pkg.sv
// shared widths, register indexes and types of the grouped quartile estimator
// no dependencies
`default_nettype none

package gqe_pkg;

   // storage sizing
   localparam int MAX_CLASSES = 64;
   localparam int IDX_W       = $clog2(MAX_CLASSES);
   localparam int FREQ_W      = 16;
   localparam int CUM_W       = FREQ_W + IDX_W;
   localparam int POS_W       = CUM_W + 2;
   localparam int DIFF_W      = FREQ_W + 2;
   localparam int NUMC_W      = 7;
   localparam int EFF_W       = (NUMC_W > IDX_W + 1) ? NUMC_W : IDX_W + 1;

   // value path
   localparam int VALUE_W     = 32;
   localparam int WIDTH_W     = 31;
   localparam int PROD_W      = DIFF_W + WIDTH_W;
   localparam int LOWER_W     = WIDTH_W + IDX_W + 3;
   localparam int DIV_CNT_W   = $clog2(WIDTH_W);
   localparam int QNUM_W      = 2;

   // class queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // control registers
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLASSES       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_LOWER_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_WIDTH       = 2'd2;

   localparam logic [NUMC_W-1:0]  NUM_CLASSES_RST = 7'd1;
   localparam logic [WIDTH_W-1:0] CLASS_WIDTH_RST = 31'd65536;

   // quartile codes
   localparam logic [QNUM_W-1:0] QUART_1 = 2'd1;
   localparam logic [QNUM_W-1:0] QUART_2 = 2'd2;
   localparam logic [QNUM_W-1:0] QUART_3 = 2'd3;

   // one classified class
   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [IDX_W-1:0]  idx;
      logic              last;
   } gqe_entry_type;

   // class geometry seen by the back end
   typedef struct packed {
      logic [VALUE_W-1:0] first_lower_limit;
      logic [WIDTH_W-1:0] class_width;
   } gqe_cfg_type;

endpackage

`default_nettype wire

// File: design/grouped_quartile_estimator.sv
// Grouped quartile estimator, top level.
//
// req_ channel: one class frequency per transfer, classes in order. After
// num_classes transfers (clamped to 1..64) the run ends and the block emits
// three transfers on the rsp_ channel: Q1, Q2, Q3, the last one flagged by
// rsp_last_result. Values are signed Q16.16, saturated; a quartile landing in
// an empty class returns that class's lower limit with rsp_zero_frequency_hit.
// csr_ channel: register writes (0 num_classes, 1 first_lower_limit,
// 2 class_width), always ready, to be written between runs.
// Loading takes one class per cycle while the back end is in its load state,
// and the front takes up to four classes ahead into its queue. The last class
// of a run starts the search over the cumulative-count memory; each quartile
// then passes the product and the 31-step divider (both skipped for an empty
// class), the sum and the output register. Reset clears the run, the queue
// and the output valid flag and loads the register defaults. While rsp_stall
// is high the result holds and the back end waits; the front keeps taking
// classes until its queue fills.
// depends on gqe_pkg, gqe_front, gqe_queue, gqe_back
`default_nettype none

module grouped_quartile_estimator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [15:0]                   req_class_frequency,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_quartile_number,
   output logic signed [31:0]                 rsp_quartile_value,
   output logic                               rsp_zero_frequency_hit,
   output logic                               rsp_last_result,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [gqe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata
);
   import gqe_pkg::*;

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   gqe_entry_type q_push_data;
   gqe_entry_type q_pop_data;
   gqe_cfg_type   cfg;

   // accept and classify
   gqe_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_class_frequency (req_class_frequency),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .q_push              (q_push),
      .q_push_data         (q_push_data),
      .q_full              (q_full),
      .cfg                 (cfg)
   );

   // decoupling queue
   gqe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   // store, search, divide and emit
   gqe_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_empty                (q_empty),
      .q_pop                  (q_pop),
      .q_data                 (q_pop_data),
      .cfg                    (cfg),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_quartile_number    (rsp_quartile_number),
      .rsp_quartile_value     (rsp_quartile_value),
      .rsp_zero_frequency_hit (rsp_zero_frequency_hit),
      .rsp_last_result        (rsp_last_result)
   );

endmodule

`default_nettype wire

// File: design/gqe_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module gqe_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/gqe_front.sv
// front end: control registers, class counting and run-end classification
// depends on gqe_pkg
`default_nettype none

module gqe_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [15:0]                   req_class_frequency,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [gqe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata,
   output logic                               q_push,
   output gqe_pkg::gqe_entry_type             q_push_data,
   input  wire logic                          q_full,
   output gqe_pkg::gqe_cfg_type               cfg
);
   import gqe_pkg::*;

   logic [NUMC_W-1:0]  num_classes_ff, num_classes_in;
   logic [VALUE_W-1:0] first_lower_ff, first_lower_in;
   logic [WIDTH_W-1:0] class_width_ff, class_width_in;
   logic [IDX_W-1:0]   loaded_ff, loaded_in;
   logic [EFF_W-1:0]   eff_count;
   logic [EFF_W-1:0]   next_count;
   logic               run_last;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      num_classes_in = num_classes_ff;
      first_lower_in = first_lower_ff;
      class_width_in = class_width_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_CLASSES:       num_classes_in = csr_wdata[NUMC_W-1:0];
            CSR_FIRST_LOWER_LIMIT: first_lower_in = csr_wdata[VALUE_W-1:0];
            CSR_CLASS_WIDTH:       class_width_in = csr_wdata[WIDTH_W-1:0];
            default:               num_classes_in = num_classes_ff;
         endcase
      end
   end

   // run length clamped to one .. max classes
   always_comb begin
      if (num_classes_ff == '0) begin
         eff_count = EFF_W'(1);
      end else if (EFF_W'(num_classes_ff) > EFF_W'(MAX_CLASSES)) begin
         eff_count = EFF_W'(MAX_CLASSES);
      end else begin
         eff_count = EFF_W'(num_classes_ff);
      end
   end

   // classify each transfer and hand it to the queue
   assign next_count = EFF_W'(loaded_ff) + EFF_W'(1);
   assign run_last   = (next_count >= eff_count);
   assign req_stall  = q_full;
   assign q_push     = req_valid && !q_full;

   assign q_push_data.freq = req_class_frequency;
   assign q_push_data.idx  = loaded_ff;
   assign q_push_data.last = run_last;

   always_comb begin
      loaded_in = loaded_ff;
      if (q_push) begin
         loaded_in = run_last ? '0 : loaded_ff + IDX_W'(1);
      end
   end

   assign cfg.first_lower_limit = first_lower_ff;
   assign cfg.class_width       = class_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= NUM_CLASSES_RST;
         first_lower_ff <= '0;
         class_width_ff <= CLASS_WIDTH_RST;
         loaded_ff      <= '0;
      end else begin
         num_classes_ff <= num_classes_in;
         first_lower_ff <= first_lower_in;
         class_width_ff <= class_width_in;
         loaded_ff      <= loaded_in;
      end
   end

endmodule

`default_nettype wire

// File: design/gqe_queue.sv
// short class queue between front and back ends
// depends on gqe_pkg
`default_nettype none

module gqe_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  gqe_pkg::gqe_entry_type      push_data,
   input  wire logic                   pop,
   output gqe_pkg::gqe_entry_type      pop_data,
   output logic                        full,
   output logic                        empty
);
   import gqe_pkg::*;

   gqe_entry_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: design/gqe_back.sv
// back end: cumulative store, class search, bit-serial divider and result register
// depends on gqe_pkg, gqe_ram and the assertion macro header
`default_nettype none
`include "grouped_quartile_estimator_assert.svh"

module gqe_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_empty,
   output logic                          q_pop,
   input  gqe_pkg::gqe_entry_type        q_data,
   input  gqe_pkg::gqe_cfg_type          cfg,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_quartile_number,
   output logic signed [31:0]            rsp_quartile_value,
   output logic                          rsp_zero_frequency_hit,
   output logic                          rsp_last_result
);
   import gqe_pkg::*;

   typedef enum logic [2:0] {
      B_LOAD,
      B_ADDR,
      B_CMP,
      B_MUL,
      B_DIV,
      B_SUM,
      B_OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [CUM_W-1:0]           total_ff, total_in;
   logic [IDX_W-1:0]           last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [QNUM_W-1:0]          q_ff, q_in;
   logic [CUM_W-1:0]           prev_ff, prev_in;
   logic signed [LOWER_W-1:0]  lower_ff, lower_in;
   logic [FREQ_W-1:0]          freq_ff, freq_in;
   logic [DIFF_W-1:0]          diff4_ff, diff4_in;
   logic [DIFF_W-1:0]          rem_ff, rem_in;
   logic [WIDTH_W-1:0]         quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]       step_ff, step_in;
   logic                       zero_ff, zero_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [QNUM_W-1:0]          rsp_number_ff, rsp_number_in;
   logic [VALUE_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                       rsp_zero_ff, rsp_zero_in;
   logic                       rsp_last_result_ff, rsp_last_result_in;

   logic                       ram_we;
   logic [CUM_W-1:0]           wr_sum;
   logic [CUM_W-1:0]           cum;
   logic [POS_W-1:0]           pos4;
   logic [POS_W-1:0]           cum4;
   logic [POS_W-1:0]           prev4;
   logic [POS_W-1:0]           diff4_wide;
   logic [CUM_W-1:0]           freq_diff;
   logic                       match;
   logic [PROD_W-1:0]          product;
   logic [DIFF_W-1:0]          divisor;
   logic [DIFF_W:0]            shifted;
   logic [DIFF_W:0]            sub_val;
   logic                       div_ge;
   logic signed [LOWER_W-1:0]  sum;
   logic                       sat_hi;
   logic                       sat_lo;
   logic [VALUE_W-1:0]         sat_value;

   // cumulative counts, one entry per class
   gqe_ram #(
      .WIDTH (CUM_W),
      .DEPTH (MAX_CLASSES)
   ) u_cum_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_data.idx),
      .wr_data (wr_sum),
      .rd_addr (j_ff),
      .rd_data (cum)
   );

   assign wr_sum = total_ff + CUM_W'(q_data.freq);

   // quartile position in quarter units
   always_comb begin
      case (q_ff)
         QUART_1: pos4 = POS_W'(total_ff);
         QUART_2: pos4 = POS_W'({total_ff, 1'b0});
         QUART_3: pos4 = POS_W'(total_ff) + POS_W'({total_ff, 1'b0});
         default: pos4 = '0;
      endcase
   end

   // class search compare
   assign cum4       = {cum, 2'b00};
   assign prev4      = {prev_ff, 2'b00};
   assign match      = (pos4 <= cum4) || (j_ff == last_idx_ff);
   assign freq_diff  = cum - prev_ff;
   assign diff4_wide = pos4 - prev4;

   // interpolation product, then one quotient bit per cycle
   assign product = PROD_W'(diff4_ff) * PROD_W'(cfg.class_width);
   assign divisor = {freq_ff, 2'b00};
   assign shifted = {rem_ff, quo_ff[WIDTH_W-1]};
   assign div_ge  = (shifted >= {1'b0, divisor});
   assign sub_val = shifted - {1'b0, divisor};

   // lower limit plus term, saturated to 32 bits
   assign sum       = lower_ff + $signed({{(LOWER_W-WIDTH_W){1'b0}}, quo_ff});
   assign sat_hi    = !sum[LOWER_W-1] && (|sum[LOWER_W-2:VALUE_W-1]);
   assign sat_lo    = sum[LOWER_W-1] && !(&sum[LOWER_W-2:VALUE_W-1]);
   assign sat_value = sat_hi ? {1'b0, {(VALUE_W-1){1'b1}}} :
                      sat_lo ? {1'b1, {(VALUE_W-1){1'b0}}} : sum[VALUE_W-1:0];

   // sequencer
   always_comb begin
      state_in           = state_ff;
      total_in           = total_ff;
      last_idx_in        = last_idx_ff;
      j_in               = j_ff;
      q_in               = q_ff;
      prev_in            = prev_ff;
      lower_in           = lower_ff;
      freq_in            = freq_ff;
      diff4_in           = diff4_ff;
      rem_in             = rem_ff;
      quo_in             = quo_ff;
      step_in            = step_ff;
      zero_in            = zero_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_number_in      = rsp_number_ff;
      rsp_value_in       = rsp_value_ff;
      rsp_zero_in        = rsp_zero_ff;
      rsp_last_result_in = rsp_last_result_ff;
      q_pop              = 1'b0;
      ram_we             = 1'b0;
      case (state_ff)
         B_LOAD: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               ram_we   = 1'b1;
               total_in = wr_sum;
               if (q_data.last) begin
                  last_idx_in = q_data.idx;
                  j_in        = '0;
                  q_in        = QUART_1;
                  prev_in     = '0;
                  lower_in    = {{(LOWER_W-VALUE_W){cfg.first_lower_limit[VALUE_W-1]}},
                                 cfg.first_lower_limit};
                  state_in    = B_ADDR;
               end
            end
         end
         B_ADDR: begin
            state_in = B_CMP;
         end
         B_CMP: begin
            if (match) begin
               freq_in  = freq_diff[FREQ_W-1:0];
               diff4_in = diff4_wide[DIFF_W-1:0];
               zero_in  = (freq_diff == '0);
               if (freq_diff == '0) begin
                  quo_in   = '0;
                  state_in = B_SUM;
               end else begin
                  state_in = B_MUL;
               end
            end else begin
               prev_in  = cum;
               j_in     = j_ff + IDX_W'(1);
               lower_in = lower_ff + $signed({{(LOWER_W-WIDTH_W){1'b0}}, cfg.class_width});
               state_in = B_ADDR;
            end
         end
         B_MUL: begin
            rem_in   = product[PROD_W-1:WIDTH_W];
            quo_in   = product[WIDTH_W-1:0];
            step_in  = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in  = div_ge ? sub_val[DIFF_W-1:0] : shifted[DIFF_W-1:0];
            quo_in  = {quo_ff[WIDTH_W-2:0], div_ge};
            step_in = step_ff + DIV_CNT_W'(1);
            if (step_ff == DIV_CNT_W'(WIDTH_W - 1)) begin
               state_in = B_SUM;
            end
         end
         B_SUM: begin
            rsp_valid_in       = 1'b1;
            rsp_number_in      = q_ff;
            rsp_value_in       = sat_value;
            rsp_zero_in        = zero_ff;
            rsp_last_result_in = (q_ff == QUART_3);
            state_in           = B_OUT;
         end
         B_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (q_ff == QUART_3) begin
                  total_in = '0;
                  state_in = B_LOAD;
               end else begin
                  q_in     = q_ff + QNUM_W'(1);
                  state_in = B_CMP;
               end
            end
         end
         default: begin
            state_in = B_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_LOAD;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff           <= state_in;
         total_ff           <= total_in;
         rsp_valid_ff       <= rsp_valid_in;
         last_idx_ff        <= last_idx_in;
         j_ff               <= j_in;
         q_ff               <= q_in;
         prev_ff            <= prev_in;
         lower_ff           <= lower_in;
         freq_ff            <= freq_in;
         diff4_ff           <= diff4_in;
         rem_ff             <= rem_in;
         quo_ff             <= quo_in;
         step_ff            <= step_in;
         zero_ff            <= zero_in;
         rsp_number_ff      <= rsp_number_in;
         rsp_value_ff       <= rsp_value_in;
         rsp_zero_ff        <= rsp_zero_in;
         rsp_last_result_ff <= rsp_last_result_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_quartile_number    = rsp_number_ff;
   assign rsp_quartile_value     = rsp_value_ff;
   assign rsp_zero_frequency_hit = rsp_zero_ff;
   assign rsp_last_result        = rsp_last_result_ff;

   // partial remainder stays below the divisor
   `GQE_ASSERT_IMP(a_rem_below_div, clock, reset, state_ff == B_DIV, rem_ff < divisor)
   // the search never runs past the last loaded class
   `GQE_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == B_CMP, j_ff <= last_idx_ff)
   // a hit never lies before the previous cumulative count
   `GQE_ASSERT_IMP(a_pos_after_prev, clock, reset, (state_ff == B_CMP) && match, pos4 >= prev4)
   // a result is shown only from the output state
   `GQE_ASSERT_IMP(a_valid_in_out, clock, reset, rsp_valid_ff, state_ff == B_OUT)
   // the last transfer of a run clears the total and resumes loading
   `GQE_ASSERT_NXT(a_run_end, clock, reset,
      rsp_valid_ff && !rsp_stall && rsp_last_result_ff,
      (state_ff == B_LOAD) && (total_ff == '0))

endmodule

`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for grouped_quartile_estimator: streams class frequencies,
// predicts the three quartiles of every run and checks each result transfer
// depends on gqe_pkg and the grouped_quartile_estimator rtl
`timescale 1ns / 1ps

module testbench;
   import gqe_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_ITEMS  = 150;
   localparam longint unsigned QUARTER_UNITS = 4;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [QNUM_W-1:0]         number;
      logic signed [VALUE_W-1:0] value;
      logic                      zero_hit;
      logic                      last;
   } quartile_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FREQ_W-1:0] req_class_frequency = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_quartile_number;
   logic signed [31:0] rsp_quartile_value;
   logic rsp_zero_frequency_hit;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // stimulus and scoreboard state
   logic [FREQ_W-1:0]   frequencies_to_send [$];
   quartile_result_type expected_quartiles [$];
   int frequencies_issued = 0;
   int frequencies_accepted = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_start = 1'b0;
   int hold_left = 0;

   // predictor copy of the registers and the run state
   logic [NUMC_W-1:0]         model_num_classes = NUM_CLASSES_RST;
   logic signed [VALUE_W-1:0] model_first_lower = '0;
   logic [WIDTH_W-1:0]        model_class_width = CLASS_WIDTH_RST;
   logic [FREQ_W-1:0]         model_freq [MAX_CLASSES];
   logic [CUM_W-1:0]          model_cum [MAX_CLASSES];
   logic [CUM_W-1:0]          model_total = '0;
   int                        model_loaded = 0;

   grouped_quartile_estimator DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_class_frequency    (req_class_frequency),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_quartile_number    (rsp_quartile_number),
      .rsp_quartile_value     (rsp_quartile_value),
      .rsp_zero_frequency_hit (rsp_zero_frequency_hit),
      .rsp_last_result        (rsp_last_result),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // interpolated estimate of one quartile over the classes of the finished run
   function automatic quartile_result_type estimate_quartile(input logic [QNUM_W-1:0] code,
                                                             input int count);
      longint unsigned pos4, before4, diff4, term, width_u;
      longint lower, value;
      int sel;
      quartile_result_type r;
      pos4 = code;
      pos4 = pos4 * model_total;
      sel = count - 1;
      for (int j = 0; j < count; j++) begin
         if (pos4 <= QUARTER_UNITS * model_cum[j]) begin
            sel = j;
            break;
         end
      end
      before4 = (sel > 0) ? QUARTER_UNITS * model_cum[sel-1] : 0;
      width_u = model_class_width;
      lower = model_first_lower;
      lower = lower + longint'(sel) * longint'(width_u);
      r.zero_hit = (model_freq[sel] == 0);
      if (r.zero_hit) begin
         value = lower;
      end else begin
         diff4 = pos4 - before4;
         term = (diff4 * width_u) / (QUARTER_UNITS * model_freq[sel]);
         value = lower + longint'(term);
      end
      // clamp to signed q16.16
      if (value > VALUE_MAX) value = VALUE_MAX;
      if (value < VALUE_MIN) value = VALUE_MIN;
      r.number = code;
      r.value = value[31:0];
      r.last = (code == QUART_3);
      return r;
   endfunction

   // store one class; when the run is complete queue its three quartiles
   function automatic void record_class(input logic [FREQ_W-1:0] freq);
      int slot, run_length;
      slot = model_loaded;
      if (slot >= MAX_CLASSES) slot = MAX_CLASSES - 1;
      model_freq[slot] = freq;
      model_total = model_total + freq;
      model_cum[slot] = model_total;
      model_loaded = slot + 1;
      run_length = model_num_classes;
      if (run_length == 0) run_length = 1;
      if (run_length > MAX_CLASSES) run_length = MAX_CLASSES;
      if (model_loaded >= run_length) begin
         expected_quartiles.push_back(estimate_quartile(QUART_1, model_loaded));
         expected_quartiles.push_back(estimate_quartile(QUART_2, model_loaded));
         expected_quartiles.push_back(estimate_quartile(QUART_3, model_loaded));
         model_total = '0;
         model_loaded = 0;
      end
   endfunction

   // sender: offers queued frequencies, holds the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_class_frequency <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            record_class(req_class_frequency);
            frequencies_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (frequencies_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_class_frequency <= frequencies_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: a long hold when requested, otherwise random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_start) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      quartile_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quartiles.size() == 0) begin
            $error("quartile transfer with none expected: number %0d value %0d",
                   rsp_quartile_number, rsp_quartile_value);
            mismatch_count++;
         end else begin
            want = expected_quartiles.pop_front();
            if (rsp_quartile_number !== want.number) begin
               $error("quartile_number: expected %0d, got %0d", want.number,
                      rsp_quartile_number);
               mismatch_count++;
            end
            if (rsp_quartile_value !== want.value) begin
               $error("quartile_value: expected %0d, got %0d", want.value,
                      rsp_quartile_value);
               mismatch_count++;
            end
            if (rsp_zero_frequency_hit !== want.zero_hit) begin
               $error("zero_frequency_hit: expected %0d, got %0d", want.zero_hit,
                      rsp_zero_frequency_hit);
               mismatch_count++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %0d, got %0d", want.last, rsp_last_result);
               mismatch_count++;
            end
         end
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 56;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            recv_stall_pct = 56;
         end
         default: begin
            send_idle_pct = 38;
            recv_stall_pct = 38;
         end
      endcase
   endtask

   task automatic queue_frequency(input logic [FREQ_W-1:0] freq);
      frequencies_to_send.push_back(freq);
      frequencies_issued++;
   endtask

   // every class taken, every quartile seen, then let the back end finish loading
   task automatic wait_until_idle();
      while (frequencies_accepted != frequencies_issued || expected_quartiles.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_NUM_CLASSES:       model_num_classes = data[NUMC_W-1:0];
         CSR_FIRST_LOWER_LIMIT: model_first_lower = data;
         CSR_CLASS_WIDTH:       model_class_width = data[WIDTH_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] num, input logic [31:0] lower,
                            input logic [31:0] width);
      write_register(CSR_NUM_CLASSES, num);
      write_register(CSR_FIRST_LOWER_LIMIT, lower);
      write_register(CSR_CLASS_WIDTH, width);
   endtask

   function automatic logic [FREQ_W-1:0] random_frequency();
      case ($urandom_range(9))
         0: return '0;
         1: return 16'hFFFF;
         2: return FREQ_W'($urandom_range(15));
         3, 4, 5: return FREQ_W'($urandom_range(16'hFFFF));
         default: return FREQ_W'($urandom_range(1000, 1));
      endcase
   endfunction

   function automatic logic [31:0] random_lower_limit();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [31:0] random_class_width();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'h7FFF_FFFF;
         2: return $urandom & 32'h7FFF_FFFF;
         default: return $urandom_range(32'h0010_0000, 1);
      endcase
   endfunction

   function automatic logic [31:0] random_num_classes();
      case ($urandom_range(19))
         0: return 0;
         1: return MAX_CLASSES;
         2: return $urandom_range(127, MAX_CLASSES + 1);
         3, 4, 5, 6: return $urandom_range(16, 9);
         default: return $urandom_range(8, 1);
      endcase
   endfunction

   // stimulus sequence
   initial begin
      int random_sent, run_length, count, phase;
      logic [31:0] num;
      random_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain run of four classes
      set_idling(IDLE_NONE);
      configure(4, 0, 32'h0001_0000);
      queue_frequency(16'd10);
      queue_frequency(16'd20);
      queue_frequency(16'd30);
      queue_frequency(16'd40);
      // total count zero
      repeat (4) queue_frequency(16'd0);
      wait_until_idle();
      // largest frequencies, upper limits of both geometry registers, positive overflow
      set_idling(IDLE_BOTH);
      configure(4, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      repeat (4) queue_frequency(16'hFFFF);
      wait_until_idle();
      // single-class runs, zero width at the most negative lower limit
      configure(1, 32'h8000_0000, 0);
      queue_frequency(16'hFFFF);
      wait_until_idle();
      write_register(CSR_NUM_CLASSES, 0);
      queue_frequency(16'd1);
      wait_until_idle();
      // empty class in the middle, negative lower limit
      set_idling(IDLE_RECEIVER);
      configure(3, 32'hFFFA_8000, 32'h0001_8000);
      queue_frequency(16'd3);
      queue_frequency(16'd0);
      queue_frequency(16'd9);
      wait_until_idle();
      // run length cut short partway through a run
      set_idling(IDLE_SENDER);
      write_register(CSR_NUM_CLASSES, 8);
      queue_frequency(16'd5);
      queue_frequency(16'd7);
      queue_frequency(16'd11);
      wait_until_idle();
      write_register(CSR_NUM_CLASSES, 2);
      queue_frequency(16'd13);
      wait_until_idle();

      // long receiver hold while classes keep coming
      set_idling(IDLE_NONE);
      configure(2, 0, 32'h0001_0000);
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (30) queue_frequency(random_frequency());
      wait_until_idle();

      // random runs, sometimes leaving a partial run for the next setting
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         set_idling(idle_mode_type'(phase % 4));
         num = (phase == 0) ? $urandom_range(127, MAX_CLASSES) : random_num_classes();
         configure(num, random_lower_limit(), random_class_width());
         run_length = num[NUMC_W-1:0];
         if (run_length == 0) run_length = 1;
         if (run_length > MAX_CLASSES) run_length = MAX_CLASSES;
         count = (run_length > 16) ? run_length : run_length * $urandom_range(3, 1);
         if (run_length > 1 && $urandom_range(4) == 0)
            count = count + $urandom_range(run_length - 1, 1);
         repeat (count) queue_frequency(random_frequency());
         random_sent = random_sent + count;
         wait_until_idle();
         phase++;
      end

      wait_until_idle();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: grouped_quartile_estimator.f
+incdir+design
design/gqe_pkg.sv
design/gqe_ram.sv
design/gqe_front.sv
design/gqe_queue.sv
design/gqe_back.sv
design/grouped_quartile_estimator.sv
sim/testbench.sv
